[design/pfba_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfba_pkg
// Shared types, codes and helpers of the page frame bitmap allocator.
// ---------------------------------------------------------------------------
package pfba_pkg;

  localparam int NUM_PAGES_DEF = 65536;
  localparam int WORD_BITS     = 64;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_MARK  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OOM       = 2'd1;
  localparam logic [1:0] ST_PROTECTED = 2'd2;

  localparam logic [WORD_BITS-1:0] ALL_BUSY = '1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] page_number;
    logic [16:0] page_count;
    logic        usable;
  } pfba_in_t;

  typedef struct packed {
    logic [15:0] granted_page;
    logic [1:0]  status;
  } pfba_out_t;

  // lowest clear bit of a word: byte first, then bit within the byte
  function automatic logic [5:0] first_zero(input logic [WORD_BITS-1:0] w);
    logic [7:0] byte_open;
    logic [2:0] bsel;
    logic [7:0] sel_byte;
    logic [2:0] pos;
    for (int i = 0; i < 8; i++) begin
      byte_open[i] = ~&w[8*i +: 8];
    end
    bsel = '0;
    for (int i = 7; i >= 0; i--) begin
      if (byte_open[i]) bsel = 3'(i);
    end
    sel_byte = w[8*bsel +: 8];
    pos = '0;
    for (int i = 7; i >= 0; i--) begin
      if (!sel_byte[i]) pos = 3'(i);
    end
    return {bsel, pos};
  endfunction

endpackage

[design/pfba_bitmap_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfba_bitmap_ram
// Bitmap store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module pfba_bitmap_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [AW-1:0]                  rd_addr,
  output logic [pfba_pkg::WORD_BITS-1:0] rd_data,
  input  logic                           wr_en,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [pfba_pkg::WORD_BITS-1:0] wr_data
);
  import pfba_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/pfba_seq.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfba_seq
// Transaction sequencer: clearing pass, word scan for allocation,
// read-modify-write of bitmap words for free and region marking.
// ---------------------------------------------------------------------------
module pfba_seq #(
  parameter int NUM_PAGES = 65536
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  pfba_pkg::pfba_in_t                         in_data,
  input  logic [15:0]                                protect_limit,
  output logic                                       res_valid,
  output pfba_pkg::pfba_out_t                        res_data,
  input  logic                                       res_ready,
  output logic                                       mem_rd_en,
  output logic [$clog2(NUM_PAGES/pfba_pkg::WORD_BITS > 1 ?
                       NUM_PAGES/pfba_pkg::WORD_BITS : 2)-1:0] mem_rd_addr,
  input  logic [pfba_pkg::WORD_BITS-1:0]             mem_rd_data,
  output logic                                       mem_wr_en,
  output logic [$clog2(NUM_PAGES/pfba_pkg::WORD_BITS > 1 ?
                       NUM_PAGES/pfba_pkg::WORD_BITS : 2)-1:0] mem_wr_addr,
  output logic [pfba_pkg::WORD_BITS-1:0]             mem_wr_data
);
  import pfba_pkg::*;

  localparam int WORDS = NUM_PAGES / WORD_BITS;
  localparam int AW    = $clog2(WORDS > 1 ? WORDS : 2);
  localparam int TW    = $clog2(NUM_PAGES + 1);
  localparam int PW    = (TW > 18) ? TW : 18;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FREE = 3'd3;
  localparam logic [2:0] S_MARK = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  logic [2:0]      state_r, state_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [AW:0]     words_r, words_nxt;
  logic [AW-1:0]   first_r, first_nxt;
  logic [AW-1:0]   last_r, last_nxt;
  logic [5:0]      lo_r, lo_nxt;
  logic [5:0]      hi_r, hi_nxt;
  logic            usable_r, usable_nxt;
  logic [1:0]      op_r, op_nxt;
  logic [TW-1:0]   total_r, total_nxt;
  pfba_out_t       res_r, res_nxt;

  logic [AW:0]     idx_inc;
  logic [AW:0]     words_now;
  logic [PW-1:0]   page_pos;
  logic [PW-1:0]   sum_pos;
  logic [PW-1:0]   end_pos;
  logic [PW-1:0]   end_m1;
  logic            page_ok;
  logic [AW-1:0]   page_word;
  logic [AW-1:0]   end_word;
  logic [5:0]      fz;
  logic [5:0]      lo_eff, hi_eff;
  logic [WORD_BITS-1:0] run_mask;

  assign idx_inc   = {1'b0, idx_r} + 1'b1;
  assign words_now = (AW+1)'(total_r >> 6);
  assign page_pos  = PW'(in_data.page_number);
  assign sum_pos   = page_pos + PW'(in_data.page_count);
  assign end_pos   = (sum_pos > PW'(NUM_PAGES)) ? PW'(NUM_PAGES) : sum_pos;
  assign end_m1    = end_pos - 1'b1;
  assign page_ok   = page_pos < PW'(NUM_PAGES);
  assign page_word = page_pos[AW+5:6];
  assign end_word  = end_m1[AW+5:6];
  assign fz        = first_zero(mem_rd_data);
  assign lo_eff    = (idx_r == first_r) ? lo_r : 6'd0;
  assign hi_eff    = (idx_r == last_r) ? hi_r : 6'd63;
  assign run_mask  = (ALL_BUSY << lo_eff) & (ALL_BUSY >> (6'd63 - hi_eff));

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    words_nxt   = words_r;
    first_nxt   = first_r;
    last_nxt    = last_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    usable_nxt  = usable_r;
    op_nxt      = op_r;
    total_nxt   = total_r;
    res_nxt     = res_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = idx_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = idx_r;
    mem_wr_data = '0;
    case (state_r)
      S_CLR: begin
        mem_wr_en = 1'b1;
        if (idx_inc == (AW+1)'(WORDS)) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_inc[AW-1:0];
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.operation;
          res_nxt   = '{granted_page: 16'd0, status: ST_OK};
          state_nxt = S_RESP;
          case (in_data.operation)
            OP_ALLOC: begin
              if (words_now == '0) begin
                res_nxt.status = ST_OOM;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
                idx_nxt     = '0;
                words_nxt   = words_now;
                state_nxt   = S_SCAN;
              end
            end
            OP_FREE: begin
              if (in_data.page_number <= protect_limit) begin
                res_nxt.status = ST_PROTECTED;
              end else if (page_ok) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = page_word;
                idx_nxt     = page_word;
                lo_nxt      = in_data.page_number[5:0];
                state_nxt   = S_FREE;
              end
            end
            OP_MARK: begin
              if (PW'(in_data.page_count) >= PW'(NUM_PAGES) - PW'(total_r)) begin
                total_nxt = TW'(NUM_PAGES);
              end else begin
                total_nxt = total_r + TW'(in_data.page_count);
              end
              if (in_data.page_count != '0 && page_ok) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = page_word;
                idx_nxt     = page_word;
                first_nxt   = page_word;
                last_nxt    = end_word;
                lo_nxt      = in_data.page_number[5:0];
                hi_nxt      = end_m1[5:0];
                usable_nxt  = in_data.usable;
                state_nxt   = S_MARK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (mem_rd_data != ALL_BUSY) begin
          state_nxt = S_RESP;
          if (idx_r == '0 && fz == 6'd0) begin
            res_nxt.status = ST_OOM;
          end else begin
            mem_wr_en            = 1'b1;
            mem_wr_data          = mem_rd_data | (WORD_BITS'(1) << fz);
            res_nxt.granted_page = 16'({idx_r, fz});
          end
        end else if (idx_inc == words_r) begin
          res_nxt.status = ST_OOM;
          state_nxt      = S_RESP;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_inc[AW-1:0];
          idx_nxt     = idx_inc[AW-1:0];
        end
      end
      S_FREE: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = mem_rd_data & ~(WORD_BITS'(1) << lo_r);
        state_nxt   = S_RESP;
      end
      S_MARK: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = usable_r ? (mem_rd_data & ~run_mask) : (mem_rd_data | run_mask);
        if (idx_r == last_r) begin
          state_nxt = S_RESP;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_inc[AW-1:0];
          idx_nxt     = idx_inc[AW-1:0];
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      idx_r   <= '0;
      total_r <= '0;
      op_r    <= OP_MARK;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      total_r <= total_nxt;
      op_r    <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    words_r  <= words_nxt;
    first_r  <= first_nxt;
    last_r   <= last_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    usable_r <= usable_nxt;
    res_r    <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign res_data  = res_r;

  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TW'(NUM_PAGES))
    else $error("page total above capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
    else $error("read and write of the same bitmap word in one cycle");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_wr_en)
    else $error("bitmap write while idle");

  a_alloc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && op_r == OP_ALLOC && res_r.status == ST_OK) |->
      (res_r.granted_page != 16'd0 || NUM_PAGES > 65536))
    else $error("allocation granted page zero");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction taken while busy");

endmodule

[design/page_frame_bitmap_allocator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// page_frame_bitmap_allocator
// First-fit page frame allocator over a one-bit-per-page bitmap memory.
// ---------------------------------------------------------------------------
// One transaction is in work at a time; the bitmap sits in a single-port-write,
// single-port-read memory of NUM_PAGES/64 words with registered read data,
// and allocate, free and mark region work by read-modify-write of those words.
// After reset a clearing pass writes one word per cycle over all NUM_PAGES/64
// words (1024 at the default size) with in_ready low; cfg writes are taken at
// any time. Allocate scans one word per cycle, up to total/64 words; mark
// region visits each word the region touches; protected frees, frees beyond
// capacity, empty regions, allocation with fewer than 64 pages in the total
// and unused codes go straight to the result. After handing its result on,
// the sequencer returns to idle before it takes the next transaction. The
// result sits in an output register, so the next transaction may be accepted
// while the previous result waits.
module page_frame_bitmap_allocator #(
  parameter int NUM_PAGES = pfba_pkg::NUM_PAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfba_pkg::pfba_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pfba_pkg::pfba_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import pfba_pkg::*;

  localparam int WORDS = NUM_PAGES / WORD_BITS;
  localparam int AW    = $clog2(WORDS > 1 ? WORDS : 2);

  logic [15:0]          protect_r;
  logic                 out_valid_r;
  pfba_out_t            out_data_r;
  logic                 res_valid;
  logic                 res_ready;
  pfba_out_t            res_data;
  logic                 mem_rd_en;
  logic [AW-1:0]        mem_rd_addr;
  logic [WORD_BITS-1:0] mem_rd_data;
  logic                 mem_wr_en;
  logic [AW-1:0]        mem_wr_addr;
  logic [WORD_BITS-1:0] mem_wr_data;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      protect_r <= '0;
    end else if (cfg_valid) begin
      protect_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  pfba_seq #(
    .NUM_PAGES (NUM_PAGES)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .protect_limit (protect_r),
    .res_valid     (res_valid),
    .res_data      (res_data),
    .res_ready     (res_ready),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data)
  );

  pfba_bitmap_ram #(
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

endmodule
